>>> hdl/euler_angles_to_rotation_matrix_core_macros.svh
// assertion macros used by the checker file
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define EARM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define EARM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/earm_pkg.sv
`default_nettype none
package earm_pkg;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 14;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int Q_INNER           = 30;
    localparam int OUT_W             = 16;
    localparam int IN_W              = 16;
    localparam int DATA_W            = 32;
    localparam logic signed [DATA_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    // internal sine/cosine magnitude stays below 2^31 in q30 after growth
    localparam int PROD_W = 2 * DATA_W;

    typedef logic signed [DATA_W-1:0] q30_t;

    typedef struct packed {
        q30_t x;
        q30_t y;
        q30_t z;
        logic flip;
    } cord_lane_t;

    typedef struct packed {
        cord_lane_t yaw;
        cord_lane_t pitch;
        cord_lane_t roll;
    } cord_row_t;

    function automatic logic [31:0] atan_units(input int idx);
        logic [31:0] t;
        case (idx)
            0:  t = 32'h20000000;  1:  t = 32'h12E4051E;
            2:  t = 32'h09FB385B;  3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;  9:  t = 32'h00145F2F;
            10: t = 32'h000A2F98;  11: t = 32'h000517CC;
            12: t = 32'h00028BE6;  13: t = 32'h000145F3;
            14: t = 32'h0000A2FA;  15: t = 32'h0000517D;
            16: t = 32'h000028BE;  17: t = 32'h0000145F;
            18: t = 32'h00000A30;  19: t = 32'h00000518;
            20: t = 32'h0000028C;  21: t = 32'h00000146;
            22: t = 32'h000000A3;  23: t = 32'h00000051;
            24: t = 32'h00000029;  25: t = 32'h00000014;
            26: t = 32'h0000000A;  27: t = 32'h00000005;
            28: t = 32'h00000003;  29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

    // q30 product, floor shifted back to q30
    function automatic q30_t qmul(input q30_t a, input q30_t b);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        return q30_t'(p >>> Q_INNER);
    endfunction

    // round to fraction bits and saturate to plus or minus one
    function automatic logic [OUT_W-1:0] to_out(input logic signed [DATA_W+1:0] v,
                                                input int frac);
        logic signed [DATA_W+1:0] r;
        logic signed [DATA_W+1:0] one;
        one = (DATA_W+2)'(1) <<< frac;
        if (Q_INNER - frac > 0)
            r = (v + ((DATA_W+2)'(1) <<< (Q_INNER - frac - 1))) >>> (Q_INNER - frac);
        else
            r = v;
        if (r > one) r = one;
        if (r < -one) r = -one;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[OUT_W-1:0];
    endfunction
endpackage
`default_nettype wire

>>> hdl/earm_cordic_cell.sv
`default_nettype none
module earm_cordic_cell import earm_pkg::*; #(
    parameter int STAGE = 0
) (
    input  wire logic       aclk,
    input  wire logic       en,
    input  wire cord_lane_t lane_in,
    output cord_lane_t      lane_out
);
    localparam int SH = (STAGE > 31) ? 31 : STAGE;
    localparam q30_t ATAN = q30_t'(atan_units(STAGE));

    cord_lane_t lane_reg;
    cord_lane_t lane_next;

    always_comb begin
        lane_next = lane_in;
        if (!lane_in.z[DATA_W-1]) begin
            lane_next.x = lane_in.x - (lane_in.y >>> SH);
            lane_next.y = lane_in.y + (lane_in.x >>> SH);
            lane_next.z = lane_in.z - ATAN;
        end else begin
            lane_next.x = lane_in.x + (lane_in.y >>> SH);
            lane_next.y = lane_in.y - (lane_in.x >>> SH);
            lane_next.z = lane_in.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;
endmodule
`default_nettype wire

>>> hdl/euler_angles_to_rotation_matrix_core.sv
// channel | ports            | beat contents
// input   | s_axis_t*        | tdata: yaw, pitch, roll (16 bits each)
// output  | m_axis_t*        | tdata: r00..r22 (16 bits each, signed q2.14)
//
// one beat per cycle sustained while m_axis_tready does not stall the output;
// the pipe is a row of cordic cells (one per stage and angle) and three product stages
// aresetn is synchronous, active low, and clears only the valid bits
// the whole pipe advances when the output register is empty or taken
`default_nettype none
module euler_angles_to_rotation_matrix_core import earm_pkg::*; #(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // yaw [15:0], pitch [31:16], roll [47:32]
    input  wire logic [47:0]   s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // r00 r01 r02 r10 r11 r12 r20 r21 r22, 16 bits each from bit 0
    output logic [143:0]       m_axis_tdata
);
    localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LAT = NST + 3;

    // global advance: everything moves together, output is a register
    logic adv;
    logic [LAT-1:0] vld_reg;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // quadrant fold into a cordic start lane
    // bits above ANGLE_BITS fall off the top of the 32-bit turn
    function automatic cord_lane_t fold(input logic [IN_W-1:0] raw);
        logic [31:0] a;
        cord_lane_t l;
        a = 32'(raw) << (32 - ANGLE_BITS);
        l.flip = 1'b0;
        if (a[31] ^ a[30]) begin
            a = a - 32'h80000000;
            l.flip = 1'b1;
        end
        l.x = CORDIC_GAIN_Q30;
        l.y = '0;
        l.z = q30_t'(a);
        return l;
    endfunction

    cord_row_t row [NST+1];
    assign row[0].yaw   = fold(s_axis_tdata[15:0]);
    assign row[0].pitch = fold(s_axis_tdata[31:16]);
    assign row[0].roll  = fold(s_axis_tdata[47:32]);

    for (genvar g = 0; g < NST; g++) begin : g_cell
        earm_cordic_cell #(.STAGE(g)) u_yaw (
            .aclk(aclk), .en(adv), .lane_in(row[g].yaw), .lane_out(row[g+1].yaw));
        earm_cordic_cell #(.STAGE(g)) u_pitch (
            .aclk(aclk), .en(adv), .lane_in(row[g].pitch), .lane_out(row[g+1].pitch));
        earm_cordic_cell #(.STAGE(g)) u_roll (
            .aclk(aclk), .en(adv), .lane_in(row[g].roll), .lane_out(row[g+1].roll));
    end

    // sines and cosines after undoing the fold
    q30_t sy, cy, sp, cp, sr, cr;
    assign cy = row[NST].yaw.flip   ? -row[NST].yaw.x   : row[NST].yaw.x;
    assign sy = row[NST].yaw.flip   ? -row[NST].yaw.y   : row[NST].yaw.y;
    assign cp = row[NST].pitch.flip ? -row[NST].pitch.x : row[NST].pitch.x;
    assign sp = row[NST].pitch.flip ? -row[NST].pitch.y : row[NST].pitch.y;
    assign cr = row[NST].roll.flip  ? -row[NST].roll.x  : row[NST].roll.x;
    assign sr = row[NST].roll.flip  ? -row[NST].roll.y  : row[NST].roll.y;

    // product stage 1: register the trig values plus the roll-pitch products
    q30_t sy_reg, cy_reg, sp_reg, cp_reg, sr_reg, cr_reg, srsp_reg, crsp_reg;
    // product stage 2: all two-term products and the negated pitch sine
    q30_t p00_reg, p01_reg, p02_reg, p12_reg, p22_reg;
    q30_t a10_reg, b10_reg, a11_reg, b11_reg, a20_reg, b20_reg, a21_reg, b21_reg;
    logic [143:0] out_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sy_reg <= sy; cy_reg <= cy; sp_reg <= sp; cp_reg <= cp;
            sr_reg <= sr; cr_reg <= cr;
            srsp_reg <= qmul(sr, sp);
            crsp_reg <= qmul(cr, sp);

            p00_reg <= qmul(cp_reg, cy_reg);
            p01_reg <= qmul(cp_reg, sy_reg);
            p02_reg <= -sp_reg;
            p12_reg <= qmul(sr_reg, cp_reg);
            p22_reg <= qmul(cr_reg, cp_reg);
            a10_reg <= qmul(srsp_reg, cy_reg); b10_reg <= qmul(cr_reg, sy_reg);
            a11_reg <= qmul(srsp_reg, sy_reg); b11_reg <= qmul(cr_reg, cy_reg);
            a20_reg <= qmul(crsp_reg, cy_reg); b20_reg <= qmul(sr_reg, sy_reg);
            a21_reg <= qmul(crsp_reg, sy_reg); b21_reg <= qmul(sr_reg, cy_reg);

            out_reg[15:0]    <= to_out(34'(p00_reg), FRACTION_BITS);
            out_reg[31:16]   <= to_out(34'(p01_reg), FRACTION_BITS);
            out_reg[47:32]   <= to_out(34'(p02_reg), FRACTION_BITS);
            out_reg[63:48]   <= to_out(34'(a10_reg) - 34'(b10_reg), FRACTION_BITS);
            out_reg[79:64]   <= to_out(34'(a11_reg) + 34'(b11_reg), FRACTION_BITS);
            out_reg[95:80]   <= to_out(34'(p12_reg), FRACTION_BITS);
            out_reg[111:96]  <= to_out(34'(a20_reg) + 34'(b20_reg), FRACTION_BITS);
            out_reg[127:112] <= to_out(34'(a21_reg) - 34'(b21_reg), FRACTION_BITS);
            out_reg[143:128] <= to_out(34'(p22_reg), FRACTION_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = out_reg;
endmodule
`default_nettype wire

>>> hdl/earm_checker.sv
`default_nettype none
`include "euler_angles_to_rotation_matrix_core_macros.svh"
module earm_checker import earm_pkg::*; (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [143:0] m_axis_tdata
);
    // stalled result beat holds its data
    `EARM_ASSERT_NXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed under stall")
    // input side is ready whenever the output register is free
    `EARM_ASSERT_IMP(a_rdy, aclk, aresetn, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input blocked with free output")
    // diagonal entry r22 stays within plus or minus one
    `EARM_ASSERT_IMP(a_rng, aclk, aresetn, m_axis_tvalid, ($signed(m_axis_tdata[143:128]) <= 16384) && ($signed(m_axis_tdata[143:128]) >= -16384), "entry out of range")
endmodule

bind euler_angles_to_rotation_matrix_core earm_checker u_earm_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
